### hdl/nonrestoring_unsigned_divider_assert.svh
// Assertion macros shared by the divider checker.
// Clocked concurrent assertions that report through $error.
`ifndef NONRESTORING_UNSIGNED_DIVIDER_ASSERT_SVH
`define NONRESTORING_UNSIGNED_DIVIDER_ASSERT_SVH

// Checked at every clock edge, reset included.
`define NUD_ASSERT(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

// Checked only while reset is low.
`define NUD_ASSERT_RUN(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

`endif

### hdl/nud_pkg.sv
// Package for the non-restoring unsigned divider.
// Holds the operand widths and the pipeline stage record; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package nud_pkg;

   localparam int DivWidth = 8;
   localparam int AccWidth = DivWidth + 1;
   localparam int DataWidth = 2 * DivWidth;

   typedef struct packed {
      logic [AccWidth-1:0] acc;
      logic [DivWidth-1:0] dvd;
      logic [DivWidth-1:0] quo;
      logic [DivWidth-1:0] dvs;
   } stage_type;

endpackage

`default_nettype wire

### hdl/nonrestoring_unsigned_divider.sv
// Non-restoring unsigned divider, one add/subtract stage per quotient bit.
// A beat enters every cycle while req_tready is high; its result beat passes
// through DivWidth + 1 register stages: one per quotient bit, each holding a
// single add or subtract of the divisor, and one output stage for the final
// remainder correction. Every stage has its own valid bit and moves forward
// whenever the stage after it is empty or moving, so a stalled result holds
// only the stages behind it while empty stages keep taking beats. A zero
// divisor gives an all-ones quotient, the dividend as remainder and the flag
// in rsp_tuser. Uses nud_pkg.
`timescale 1ns / 1ps
`default_nettype none

module nonrestoring_unsigned_divider (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_tvalid,
   output logic                               req_tready,
   input  wire logic [nud_pkg::DataWidth-1:0] req_tdata,  // dividend, divisor
   output logic                               rsp_tvalid,
   input  wire logic                          rsp_tready,
   output logic [nud_pkg::DataWidth-1:0]      rsp_tdata,  // quotient, remainder
   output logic                               rsp_tuser   // divide_by_zero
);

   import nud_pkg::*;

   stage_type               stage_ff  [DivWidth];
   stage_type               stage_in  [DivWidth];
   stage_type               stage_src [DivWidth];
   logic [DivWidth-1:0]     valid_ff;
   logic [DivWidth-1:0]     valid_src;
   logic [DivWidth:0]       adv;

   logic [DataWidth-1:0]    rsp_data_ff;
   logic [DataWidth-1:0]    rsp_data_in;
   logic                    rsp_user_ff;
   logic                    rsp_user_in;
   logic                    rsp_valid_ff;
   logic [AccWidth-1:0]     rem_full;

   assign stage_src[0] = '{acc: '0,
                           dvd: req_tdata[DivWidth-1:0],
                           quo: '0,
                           dvs: req_tdata[DataWidth-1:DivWidth]};
   assign valid_src[0] = req_tvalid;
   assign adv[DivWidth] = !rsp_valid_ff || rsp_tready;
   assign req_tready = adv[0];

   for (genvar s = 0; s < DivWidth; s++) begin : g_step
      logic [AccWidth-1:0] acc_sh;
      logic [AccWidth-1:0] acc_new;

      if (s > 0) begin : g_link
         assign stage_src[s] = stage_ff[s-1];
         assign valid_src[s] = valid_ff[s-1];
      end

      assign adv[s] = !valid_ff[s] || adv[s+1];

      always_comb begin
         acc_sh = {stage_src[s].acc[DivWidth-1:0], stage_src[s].dvd[DivWidth-1]};
         if (stage_src[s].acc[DivWidth]) begin
            acc_new = acc_sh + {1'b0, stage_src[s].dvs};
         end else begin
            acc_new = acc_sh - {1'b0, stage_src[s].dvs};
         end
         stage_in[s] = '{acc: acc_new,
                         dvd: {stage_src[s].dvd[DivWidth-2:0], 1'b0},
                         quo: {stage_src[s].quo[DivWidth-2:0], ~acc_new[DivWidth]},
                         dvs: stage_src[s].dvs};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[s] <= 1'b0;
         end else if (adv[s]) begin
            valid_ff[s] <= valid_src[s];
         end
         if (adv[s]) begin
            stage_ff[s] <= stage_in[s];
         end
      end
   end

   always_comb begin
      if (stage_ff[DivWidth-1].acc[DivWidth]) begin
         rem_full = stage_ff[DivWidth-1].acc + {1'b0, stage_ff[DivWidth-1].dvs};
      end else begin
         rem_full = stage_ff[DivWidth-1].acc;
      end
      rsp_data_in = {rem_full[DivWidth-1:0], stage_ff[DivWidth-1].quo};
      rsp_user_in = (stage_ff[DivWidth-1].dvs == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv[DivWidth]) begin
         rsp_valid_ff <= valid_ff[DivWidth-1];
      end
      if (adv[DivWidth]) begin
         rsp_data_ff <= rsp_data_in;
         rsp_user_ff <= rsp_user_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule

`default_nettype wire

### hdl/nud_checker.sv
// Port-level checker for the non-restoring unsigned divider, bound to the top.
// Uses nud_pkg and the macros in nonrestoring_unsigned_divider_assert.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "nonrestoring_unsigned_divider_assert.svh"

module nud_checker (
   input wire logic                          clock,
   input wire logic                          reset,
   input wire logic                          req_tvalid,
   input wire logic                          req_tready,
   input wire logic [nud_pkg::DataWidth-1:0] req_tdata,  // dividend, divisor
   input wire logic                          rsp_tvalid,
   input wire logic                          rsp_tready,
   input wire logic [nud_pkg::DataWidth-1:0] rsp_tdata,  // quotient, remainder
   input wire logic                          rsp_tuser   // divide_by_zero
);

   import nud_pkg::*;

   `NUD_ASSERT(a_reset_empty, clock, reset |=> !rsp_tvalid && req_tready, "divider not empty after reset")
   `NUD_ASSERT(a_zero_quo, clock, rsp_tvalid && rsp_tuser |-> rsp_tdata[DivWidth-1:0] == '1, "zero divisor quotient not all ones")
   `NUD_ASSERT_RUN(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready |=> rsp_tvalid, "result beat dropped while stalled")
   `NUD_ASSERT_RUN(a_rsp_stable, clock, reset, rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata) && $stable(rsp_tuser), "stalled result beat changed")

endmodule

bind nonrestoring_unsigned_divider nud_checker u_nud_checker (.*);

`default_nettype wire
